[hw/rtl/bgrf_pkg.sv]
// bgrf_pkg: request codes, item structs and the command passed from front to back
// no dependencies; used by every module of the bit-granular ring fifo except bgrf_ram
package bgrf_pkg;

  // widest ring position (ring of up to 65536 slots) and widest transfer count
  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_FPUSH = 3'd1,
    REQ_POP   = 3'd2,
    REQ_DROP  = 3'd3,
    REQ_PEEK  = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE
  } op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] write_bits;
    logic [9:0]  bit_count;
    logic [9:0]  peek_offset;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] read_bits;
    logic [9:0]  moved_count;
    logic [9:0]  fill_bits;
    logic        is_empty;
    logic        is_full;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic [63:0]      wbits;
    out_t             res;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic chunk_pend;
  } back_stat_t;

endpackage

[hw/rtl/bit_granular_ring_fifo.sv]
// bit_granular_ring_fifo: top level of a bit fifo held in a byte ring store
// depends on bgrf_pkg, bgrf_front, bgrf_queue, bgrf_back (and bgrf_ram below it)
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------
//   in      | in_valid_i / in_ready_o | in_i  (in_t)
//   out     | out_valid_o / out_ready_i | out_o (out_t)
//
// the front takes one item a cycle while the queue has room; the back takes a
// new item only once it is done with the last and walks the n byte chunks touched
// (up to 9 for 64 bits) one by one, set by one read and one write port on the ring
// store; drop, clear, rejected and zero-count items touch no chunk in the back
// reset clears head, tail and handshake state; the store is left as it is
// a stalled output holds its result while the front keeps filling the queue
module bit_granular_ring_fifo #(
  parameter int unsigned RING_BITS     = 1024,
  parameter int unsigned MAX_XFER_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bgrf_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bgrf_pkg::out_t out_o
);

  // classified commands from the front
  bgrf_pkg::cmd_t       f_cmd, q_cmd;
  logic                 f_valid, f_ready, q_valid, q_ready;
  // back-end status, watched by the checks below
  bgrf_pkg::back_stat_t stat;

  bgrf_front #(
    .RING_BITS    (RING_BITS),
    .MAX_XFER_BITS(MAX_XFER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  // decouples classification from the store accesses
  bgrf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_i      (f_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_o       (q_cmd)
  );

  bgrf_back #(
    .RING_BITS(RING_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .cmd_i      (q_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .stat_o     (stat)
  );

`ifndef SYNTHESIS
  // no chunk may be in flight once the back has gone idle
  a_idle_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.busy |-> !stat.chunk_pend) else $error("chunk pending while back idle");

  // a handed-over command always starts work in the back
  a_cmd_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> stat.busy) else $error("command taken but back not busy");

  // a new result only comes from a command that was being worked on
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stat.busy)) else $error("result without command");
`endif

endmodule

[hw/rtl/bgrf_ram.sv]
// bgrf_ram: generic single write port, single read port ram with registered read
// no dependencies
module bgrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bgrf_front.sv]
// bgrf_front: classifies requests, keeps head and tail, builds back-end commands
// depends on bgrf_pkg
module bgrf_front #(
  parameter int unsigned RING_BITS     = 1024,
  parameter int unsigned MAX_XFER_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bgrf_pkg::in_t  in_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output bgrf_pkg::cmd_t cmd_o
);

  localparam int unsigned PW = $clog2(RING_BITS);
  localparam int unsigned EW = ((PW > 10) ? PW : 10) + 2;
  localparam logic [EW-1:0] RingE = EW'(RING_BITS);
  localparam logic [EW-1:0] CapE  = EW'(RING_BITS - 1);
  localparam logic [EW-1:0] MaxE  = EW'(MAX_XFER_BITS);

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, pos;
  logic [EW-1:0] fill, avail, cnt, off, clamp, moved, nfill;
  logic          ok;
  bgrf_pkg::op_e op;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [EW-1:0] n);
    logic [EW-1:0] s;
    s = EW'(p) + n;
    if (s >= RingE) s = s - RingE;
    return s[PW-1:0];
  endfunction

  function automatic logic [EW-1:0] fill_of(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [EW-1:0] he, te;
    he = EW'(h);
    te = EW'(t);
    if (te >= he) return te - he;
    return te + RingE - he;
  endfunction

  always_comb begin
    fill   = fill_of(head_q, tail_q);
    avail  = CapE - fill;
    cnt    = EW'(in_i.bit_count);
    off    = EW'(in_i.peek_offset);
    clamp  = (cnt < fill) ? cnt : fill;
    ok     = 1'b0;
    moved  = '0;
    op     = bgrf_pkg::OP_NONE;
    pos    = '0;
    head_d = head_q;
    tail_d = tail_q;
    unique case (in_i.req_type)
      bgrf_pkg::REQ_PUSH: begin
        if (cnt <= MaxE && cnt <= avail) begin
          ok     = 1'b1;
          moved  = cnt;
          op     = bgrf_pkg::OP_WRITE;
          pos    = tail_q;
          tail_d = adv(tail_q, cnt);
        end
      end
      bgrf_pkg::REQ_FPUSH: begin
        if (cnt <= MaxE && cnt <= CapE) begin
          if (avail < cnt) head_d = adv(head_q, cnt - avail);
          ok     = 1'b1;
          moved  = cnt;
          op     = bgrf_pkg::OP_WRITE;
          pos    = tail_q;
          tail_d = adv(tail_q, cnt);
        end
      end
      bgrf_pkg::REQ_POP: begin
        if (cnt <= MaxE) begin
          ok     = 1'b1;
          moved  = clamp;
          op     = bgrf_pkg::OP_READ;
          pos    = head_q;
          head_d = adv(head_q, clamp);
        end
      end
      bgrf_pkg::REQ_DROP: begin
        ok     = 1'b1;
        moved  = clamp;
        head_d = adv(head_q, clamp);
      end
      bgrf_pkg::REQ_PEEK: begin
        if (cnt <= MaxE && off + cnt <= fill) begin
          ok    = 1'b1;
          moved = cnt;
          op    = bgrf_pkg::OP_READ;
          pos   = adv(head_q, off);
        end
      end
      bgrf_pkg::REQ_CLEAR: begin
        ok     = 1'b1;
        head_d = '0;
        tail_d = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    nfill = fill_of(head_d, tail_d);

    cmd_o.op              = op;
    cmd_o.pos             = bgrf_pkg::POS_W'(pos);
    cmd_o.len             = moved[bgrf_pkg::LEN_W-1:0];
    cmd_o.wbits           = in_i.write_bits;
    cmd_o.res.ok          = ok;
    cmd_o.res.read_bits   = '0;
    cmd_o.res.moved_count = moved[9:0];
    cmd_o.res.fill_bits   = nfill[9:0];
    cmd_o.res.is_empty    = (nfill == '0);
    cmd_o.res.is_full     = (nfill == CapE);
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (in_valid_i && cmd_ready_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

[hw/rtl/bgrf_queue.sv]
// bgrf_queue: two-entry command queue between front and back
// depends on bgrf_pkg
module bgrf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bgrf_pkg::cmd_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bgrf_pkg::cmd_t pop_o
);

  bgrf_pkg::cmd_t ent_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = ent_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[hw/rtl/bgrf_back.sv]
// bgrf_back: carries out byte-chunk reads and read-modify-writes on the ring store
// depends on bgrf_pkg and bgrf_ram
module bgrf_back #(
  parameter int unsigned RING_BITS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  bgrf_pkg::cmd_t       cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bgrf_pkg::out_t       out_o,
  output bgrf_pkg::back_stat_t stat_o
);

  localparam int unsigned PW = $clog2(RING_BITS);
  localparam int unsigned RB = (RING_BITS + 7) / 8;
  localparam int unsigned BA = $clog2(RB);
  localparam int unsigned EW = PW + 1;
  localparam int unsigned LW = bgrf_pkg::LEN_W;
  localparam logic [EW-1:0] RingE = EW'(RING_BITS);

  logic           busy_q, bv_q, out_valid_q;
  bgrf_pkg::op_e  op_q;
  logic [63:0]    wbits_q;
  bgrf_pkg::out_t res_q, out_q;
  logic [PW-1:0]  pos_q, pos_shift, pos_next;
  logic [LW-1:0]  rem_q, done_q, bdone_q;
  logic [2:0]     blo_q, lo;
  logic [3:0]     blen_q, to_byte, len;
  logic [BA-1:0]  baddr_q, raddr;
  logic [EW-1:0]  to_end, psum;
  logic [7:0]     rdata, lowmask, mask, wchunk, merged, rval;
  logic           issue, finish, we;

  always_comb begin
    lo      = pos_q[2:0];
    to_byte = 4'd8 - {1'b0, lo};
    to_end  = RingE - EW'(pos_q);
    len     = (rem_q < LW'(to_byte)) ? rem_q[3:0] : to_byte;
    // chunk stops at the ring end when the last byte is partial
    if (EW'(len) > to_end) len = to_end[3:0];
    psum = EW'(pos_q) + EW'(len);
    if (psum >= RingE) psum = psum - RingE;
    pos_next  = psum[PW-1:0];
    pos_shift = pos_q >> 3;
    raddr     = pos_shift[BA-1:0];
    issue     = busy_q && (rem_q != '0);

    lowmask = 8'((9'd1 << blen_q) - 9'd1);
    mask    = lowmask << blo_q;
    wchunk  = 8'(wbits_q >> bdone_q);
    merged  = (rdata & ~mask) | ((wchunk << blo_q) & mask);
    rval    = (rdata >> blo_q) & lowmask;
    we      = bv_q && (op_q == bgrf_pkg::OP_WRITE);
    finish  = busy_q && (rem_q == '0) && !bv_q && (!out_valid_q || out_ready_i);
  end

  bgrf_ram #(
    .WIDTH(8),
    .DEPTH(RB)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(baddr_q),
    .wdata_i(merged),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !finish) out_valid_q <= 1'b0;
      if (!busy_q) begin
        if (cmd_valid_i) begin
          busy_q  <= 1'b1;
          op_q    <= cmd_i.op;
          wbits_q <= cmd_i.wbits;
          res_q   <= cmd_i.res;
          pos_q   <= cmd_i.pos[PW-1:0];
          rem_q   <= (cmd_i.op == bgrf_pkg::OP_NONE) ? '0 : cmd_i.len;
          done_q  <= '0;
        end
      end else begin
        bv_q <= issue;
        if (issue) begin
          blo_q   <= lo;
          blen_q  <= len;
          bdone_q <= done_q;
          baddr_q <= raddr;
          pos_q   <= pos_next;
          rem_q   <= rem_q - LW'(len);
          done_q  <= done_q + LW'(len);
        end
        if (bv_q && op_q == bgrf_pkg::OP_READ) begin
          res_q.read_bits <= res_q.read_bits | (64'(rval) << bdone_q);
        end
        if (finish) begin
          out_q       <= res_q;
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end
      end
    end
  end

  assign cmd_ready_o       = !busy_q;
  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;
  assign stat_o.busy       = busy_q;
  assign stat_o.chunk_pend = bv_q;

endmodule
